[hw/rtl/olist_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the ordered array list
package olist_pkg;

    localparam int DEPTH = 8;
    localparam int VALUE_W = 32;
    localparam int CMD_W = 3;
    localparam int POS_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 4;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((FILL_W + 1) > POS_W) ? (FILL_W + 1) : POS_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHOW   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic               en;
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

[hw/rtl/ordered_array_list.sv]
`timescale 1ns / 1ps
// ordered array list top level: command decode, cell chain and result register
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_command s_item_value s_position
//   m_      | out       | m_valid m_ready m_status m_count m_entry_out m_last
//
// append, insert, remove and clear update the cell row in parallel
// show is accepted, then streams the stored entries in order through a slot mux as the result register frees
// a new request is taken while idle and the result register is free or being drained
// aresetn is synchronous and empties the list at once
module ordered_array_list (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [olist_pkg::CMD_W-1:0]                s_command,
    input  logic signed [olist_pkg::VALUE_W-1:0]       s_item_value,
    input  logic [olist_pkg::POS_W-1:0]                s_position,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [olist_pkg::STATUS_W-1:0]             m_status,
    output logic [olist_pkg::COUNT_W-1:0]              m_count,
    output logic signed [olist_pkg::VALUE_W-1:0]       m_entry_out,
    output logic                                       m_last
);

    localparam int D = olist_pkg::DEPTH;
    localparam int FW = olist_pkg::FILL_W;
    localparam int CW = olist_pkg::CMP_W;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t                         state_reg, state_next;
    logic [FW-1:0]                  fill_reg, fill_next;
    logic [olist_pkg::IDX_W-1:0]    idx_reg, idx_next;

    logic                           m_valid_reg, m_valid_next;
    logic [olist_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [olist_pkg::COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [olist_pkg::VALUE_W-1:0]  m_entry_reg, m_entry_next;
    logic                           m_last_reg, m_last_next;

    logic                           out_free;
    logic                           accept;
    olist_pkg::cell_ctrl_t          ctrl;
    logic [olist_pkg::STATUS_W-1:0] status;
    logic                           full;
    logic                           empty;
    logic [CW-1:0]                  pos_ext;
    logic [CW-1:0]                  fill_ext;
    logic [CW-1:0]                  eff_pos;
    logic                           found;
    logic [FW+olist_pkg::COUNT_W-1:0] count_wide;
    logic                           stream_last;

    logic [olist_pkg::VALUE_W-1:0]  cell_data [D];
    logic                           cell_valid [D];
    logic                           chain [D+1];
    logic                           sel [D];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign full     = (fill_reg == FW'(D));
    assign empty    = (fill_reg == '0);
    assign pos_ext  = CW'(s_position);
    assign fill_ext = CW'(fill_reg);
    assign eff_pos  = empty ? CW'(1) : pos_ext;
    assign found    = chain[D];

    always_comb begin
        status = olist_pkg::ST_OK;
        case (s_command)
            olist_pkg::CMD_APPEND: begin
                if (full) status = olist_pkg::ST_FULL;
            end
            olist_pkg::CMD_INSERT: begin
                if (full) begin
                    status = olist_pkg::ST_FULL;
                end else if (!empty &&
                             (pos_ext == '0 || pos_ext > fill_ext + CW'(1))) begin
                    status = olist_pkg::ST_BADPOS;
                end
            end
            olist_pkg::CMD_REMOVE: begin
                if (!found) status = olist_pkg::ST_NOTFOUND;
            end
            default: begin
            end
        endcase
    end

    assign ctrl.en    = accept && (status == olist_pkg::ST_OK);
    assign ctrl.op    = s_command;
    assign ctrl.value = s_item_value;

    assign chain[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < D; i++) begin : g_cell
            logic [olist_pkg::VALUE_W-1:0] l_data, r_data;
            logic                          l_valid, r_valid;

            assign sel[i] = (eff_pos == CW'(i + 1));

            if (i == 0) begin : g_head
                assign l_data  = '0;
                assign l_valid = 1'b1;
            end else begin : g_body
                assign l_data  = cell_data[i-1];
                assign l_valid = cell_valid[i-1];
            end

            if (i == D - 1) begin : g_tail
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end else begin : g_inner
                assign r_data  = cell_data[i+1];
                assign r_valid = cell_valid[i+1];
            end

            olist_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .sel         (sel[i]),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .chain_in    (chain[i]),
                .data        (cell_data[i]),
                .valid       (cell_valid[i]),
                .chain_out   (chain[i+1])
            );
        end
    endgenerate

    always_comb begin
        fill_next = fill_reg;
        if (ctrl.en) begin
            case (s_command)
                olist_pkg::CMD_APPEND: fill_next = fill_reg + FW'(1);
                olist_pkg::CMD_INSERT: fill_next = fill_reg + FW'(1);
                olist_pkg::CMD_REMOVE: fill_next = fill_reg - FW'(1);
                olist_pkg::CMD_CLEAR:  fill_next = '0;
                default:               fill_next = fill_reg;
            endcase
        end
    end

    assign count_wide  = {{olist_pkg::COUNT_W{1'b0}}, fill_next};
    assign stream_last = ((FW'(idx_reg) + FW'(1)) == fill_reg);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_entry_next  = m_entry_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == olist_pkg::CMD_SHOW) begin
                        idx_next = '0;
                        if (!empty) state_next = ST_STREAM;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_status_next = status;
                        m_count_next  = count_wide[olist_pkg::COUNT_W-1:0];
                        m_entry_next  = '0;
                        m_last_next   = 1'b1;
                    end
                end
            end
            ST_STREAM: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = olist_pkg::ST_OK;
                    m_count_next  = count_wide[olist_pkg::COUNT_W-1:0];
                    m_entry_next  = cell_data[idx_reg];
                    m_last_next   = stream_last;
                    idx_next      = idx_reg + olist_pkg::IDX_W'(1);
                    if (stream_last) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_entry_reg  <= m_entry_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_count     = m_count_reg;
    assign m_entry_out = m_entry_reg;
    assign m_last      = m_last_reg;

endmodule

[hw/rtl/olist_cell.sv]
`timescale 1ns / 1ps
// one list slot: holds an entry and shifts with its neighbors
module olist_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  olist_pkg::cell_ctrl_t               ctrl,
    input  logic                                sel,
    input  logic [olist_pkg::VALUE_W-1:0]       left_data,
    input  logic                                left_valid,
    input  logic [olist_pkg::VALUE_W-1:0]       right_data,
    input  logic                                right_valid,
    input  logic                                chain_in,
    output logic [olist_pkg::VALUE_W-1:0]       data,
    output logic                                valid,
    output logic                                chain_out
);

    logic [olist_pkg::VALUE_W-1:0] data_reg, data_next;
    logic                          valid_reg, valid_next;
    logic                          match;

    assign match = valid_reg && (data_reg == ctrl.value);

    always_comb begin
        case (ctrl.op)
            olist_pkg::CMD_INSERT: chain_out = chain_in | sel;
            olist_pkg::CMD_REMOVE: chain_out = chain_in | match;
            default:               chain_out = chain_in;
        endcase
    end

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.en) begin
            case (ctrl.op)
                olist_pkg::CMD_APPEND: begin
                    if (!valid_reg && left_valid) begin
                        data_next  = ctrl.value;
                        valid_next = 1'b1;
                    end
                end
                olist_pkg::CMD_INSERT: begin
                    if (sel) begin
                        data_next  = ctrl.value;
                        valid_next = 1'b1;
                    end else if (chain_in) begin
                        data_next  = left_data;
                        valid_next = left_valid;
                    end
                end
                olist_pkg::CMD_REMOVE: begin
                    if (chain_in || match) begin
                        data_next  = right_data;
                        valid_next = right_valid;
                    end
                end
                olist_pkg::CMD_CLEAR: begin
                    data_next  = '0;
                    valid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule
